[src/tcmas_pkg.sv]
package tcmas_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 24;
  localparam int OFFSET_W = 32;
  localparam int SCALED_W = 40;
  localparam int COUNT_W  = 32;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 136;
  localparam int OUT_TUSER_W = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [MODE_W-1:0] MODE_START_FAIL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ_FAIL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GOOD       = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_VOLTAGE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_VOLTAGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CURRENT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CURRENT = 2'd3;

  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 24'sd4096;

  typedef struct packed {
    logic                       ch;
    logic                       good;
    logic signed [SAMPLE_W-1:0] sample;
    logic [COUNT_W-1:0]         good_cnt;
    logic [COUNT_W-1:0]         fault_cnt;
  } job_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0]   gain_v;
    logic signed [OFFSET_W-1:0] offset_v;
    logic signed [GAIN_W-1:0]   gain_c;
    logic signed [OFFSET_W-1:0] offset_c;
  } cfg_t;

  typedef struct packed {
    logic                       ch;
    logic                       sample_valid;
    logic signed [SAMPLE_W-1:0] raw_value;
    logic signed [SAMPLE_W-1:0] average;
    logic signed [SCALED_W-1:0] scaled;
    logic                       status;
    logic [COUNT_W-1:0]         good_count;
    logic [COUNT_W-1:0]         fault_count;
  } res_t;

endpackage

[src/two_channel_moving_average_scaler.sv]
// Takes one converter event per request and alternates between the voltage and current
// channels on every event. A good conversion enters that channel's ring of WINDOW_LENGTH
// samples; the running sum is divided by the number of samples held with a one-bit-per-cycle
// divider. A bus error event skips the divider and the scaling steps and goes straight to
// the output state. A two-entry queue in front lets new events be accepted while one is
// being processed, and the result register lets the next event start while a result waits.
// Configuration registers should only be written while no event is in flight.
module two_channel_moving_average_scaler
  import tcmas_pkg::*;
#(
  parameter int WINDOW_LENGTH = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // raw_sample
  input  logic [MODE_W-1:0]      s_axis_tuser,  // mode
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // raw_value, average, scaled_value, good_count, fault_count
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,  // channel, sample_valid, status
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t cfg_q;
  job_t push_job, head_job;
  res_t res;
  logic push, full, head_valid, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_v   <= GAIN_RESET;
      cfg_q.offset_v <= '0;
      cfg_q.gain_c   <= GAIN_RESET;
      cfg_q.offset_c <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GAIN_VOLTAGE:   cfg_q.gain_v   <= cfg_data_i[GAIN_W-1:0];
        REG_OFFSET_VOLTAGE: cfg_q.offset_v <= cfg_data_i[OFFSET_W-1:0];
        REG_GAIN_CURRENT:   cfg_q.gain_c   <= cfg_data_i[GAIN_W-1:0];
        REG_OFFSET_CURRENT: cfg_q.offset_c <= cfg_data_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  tcmas_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .mode_i   (s_axis_tuser),
    .sample_i (s_axis_tdata[SAMPLE_W-1:0]),
    .full_i   (full),
    .push_o   (push),
    .job_o    (push_job)
  );

  tcmas_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_job)
  );

  tcmas_back #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .job_pop_o   (pop),
    .cfg_i       (cfg_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {res.fault_count, res.good_count, res.scaled, res.average,
                         res.raw_value};
  assign m_axis_tuser = {res.status, res.sample_valid, res.ch};

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[1] != m_axis_tuser[2]))
    else $error("result carries both or neither of sample_valid and status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tdata[71:0] == 72'd0))
    else $error("bus error result carries nonzero sample data");
`endif

endmodule

[src/tcmas_front.sv]
module tcmas_front
  import tcmas_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                full_i,
  output logic                push_o,
  output job_t                job_o
);

  logic               ch_q, ch_d;
  logic [COUNT_W-1:0] good_q, good_d;
  logic [COUNT_W-1:0] fault_q, fault_d;
  logic               good;

  // Modes other than a good conversion, including the unused code, count as bus errors.
  assign good    = (mode_i == MODE_GOOD);
  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;

  assign good_d  = good_q + COUNT_W'(good);
  assign fault_d = fault_q + COUNT_W'(!good);
  assign ch_d    = !ch_q;

  always_comb begin
    job_o.ch        = ch_q;
    job_o.good      = good;
    job_o.sample    = good ? $signed(sample_i) : '0;
    job_o.good_cnt  = good_d;
    job_o.fault_cnt = fault_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q    <= 1'b0;
      good_q  <= '0;
      fault_q <= '0;
    end else if (push_o) begin
      ch_q    <= ch_d;
      good_q  <= good_d;
      fault_q <= fault_d;
    end
  end

endmodule

[src/tcmas_queue.sv]
module tcmas_queue
  import tcmas_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[src/tcmas_back.sv]
module tcmas_back
  import tcmas_pkg::*;
#(
  parameter int WINDOW_LENGTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic job_pop_o,
  input  cfg_t cfg_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  localparam int PosW  = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int FillW = $clog2(WINDOW_LENGTH + 1);
  localparam int SumW  = SAMPLE_W + $clog2(WINDOW_LENGTH) + 1;
  localparam int Depth = 2 * WINDOW_LENGTH;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = $clog2(SumW + 1);
  localparam logic [PosW-1:0]  LastPos   = PosW'(WINDOW_LENGTH - 1);
  localparam logic [FillW-1:0] FullLevel = FillW'(WINDOW_LENGTH);
  localparam logic [AddrW-1:0] RowOffset = AddrW'(WINDOW_LENGTH);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FETCH = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_SIGN  = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_ADD   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic signed [SAMPLE_W-1:0] mem [Depth];
  logic signed [SAMPLE_W-1:0] rd_q;
  logic [AddrW-1:0]           rd_addr, wr_addr;
  logic                       mem_we;

  logic [PosW-1:0]        pos_q  [2];
  logic [FillW-1:0]       fill_q [2];
  logic signed [SumW-1:0] sum_q  [2];

  job_t job_q;

  logic [SumW-1:0]  dvd_q;
  logic [FillW-1:0] rem_q, divisor_q;
  logic             neg_q;
  logic [CntW-1:0]  cnt_q;

  logic signed [SAMPLE_W-1:0] avg_q;
  logic signed [SCALED_W-1:0] prod_q, scaled_q;

  res_t res_q;
  logic res_valid_q;

  logic                       cur_ch;
  logic signed [SAMPLE_W-1:0] old_val;
  logic signed [SumW-1:0]     sum_d;
  logic [FillW-1:0]           fill_d;
  logic [PosW-1:0]            pos_d;
  logic [FillW:0]             trial;
  logic                       qbit;
  logic [SumW-1:0]            quot_signed;
  logic signed [GAIN_W-1:0]   gain_sel;
  logic signed [OFFSET_W-1:0] offset_sel;
  logic signed [SCALED_W-1:0] prod_d;
  logic                       out_free;

  assign cur_ch = job_q.ch;

  assign rd_addr = job_i.ch ? (RowOffset + AddrW'(pos_q[1])) : AddrW'(pos_q[0]);
  assign wr_addr = cur_ch ? (RowOffset + AddrW'(pos_q[1])) : AddrW'(pos_q[0]);
  assign mem_we  = (state_q == ST_FETCH);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= job_q.sample;
    end
    rd_q <= mem[rd_addr];
  end

  // Entries that were never written read as zero while the ring is still filling.
  assign old_val = (fill_q[cur_ch] == FullLevel) ? rd_q : '0;
  assign sum_d   = sum_q[cur_ch] - SumW'(old_val) + SumW'(job_q.sample);
  assign fill_d  = (fill_q[cur_ch] == FullLevel) ? FullLevel : fill_q[cur_ch] + 1'b1;
  assign pos_d   = (pos_q[cur_ch] == LastPos) ? '0 : pos_q[cur_ch] + 1'b1;

  assign trial = {rem_q, dvd_q[SumW-1]};
  assign qbit  = (trial >= {1'b0, divisor_q});

  assign quot_signed = neg_q ? (~dvd_q + 1'b1) : dvd_q;

  assign gain_sel   = cur_ch ? cfg_i.gain_c : cfg_i.gain_v;
  assign offset_sel = cur_ch ? cfg_i.offset_c : cfg_i.offset_v;
  assign prod_d     = avg_q * gain_sel;

  assign out_free  = !res_valid_q || res_ready_i;
  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          state_d = job_i.good ? ST_FETCH : ST_OUT;
        end
      end
      ST_FETCH: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == CntW'(1)) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: state_d = ST_MUL;
      ST_MUL:  state_d = ST_ADD;
      ST_ADD:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        pos_q[c]  <= '0;
        fill_q[c] <= '0;
        sum_q[c]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_FETCH) begin
        pos_q[cur_ch]  <= pos_d;
        fill_q[cur_ch] <= fill_d;
        sum_q[cur_ch]  <= sum_d;
      end
      if ((state_q == ST_OUT) && out_free) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    case (state_q)
      ST_FETCH: begin
        neg_q     <= sum_d[SumW-1];
        dvd_q     <= sum_d[SumW-1] ? SumW'(-sum_d) : SumW'(sum_d);
        rem_q     <= '0;
        divisor_q <= fill_d;
        cnt_q     <= CntW'(SumW);
      end
      ST_DIV: begin
        rem_q <= qbit ? FillW'(trial - {1'b0, divisor_q}) : trial[FillW-1:0];
        dvd_q <= {dvd_q[SumW-2:0], qbit};
        cnt_q <= cnt_q - 1'b1;
      end
      ST_SIGN: avg_q    <= quot_signed[SAMPLE_W-1:0];
      ST_MUL:  prod_q   <= prod_d;
      ST_ADD:  scaled_q <= prod_q + SCALED_W'(offset_sel);
      ST_OUT: begin
        if (out_free) begin
          res_q.ch           <= job_q.ch;
          res_q.sample_valid <= job_q.good;
          res_q.raw_value    <= job_q.sample;
          res_q.average      <= job_q.good ? avg_q : '0;
          res_q.scaled       <= job_q.good ? scaled_q : '0;
          res_q.status       <= !job_q.good;
          res_q.good_count   <= job_q.good_cnt;
          res_q.fault_count  <= job_q.fault_cnt;
        end
      end
      default: ;
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[verif/tb_two_channel_moving_average_scaler.sv]
`timescale 1ns / 1ps

module tb_two_channel_moving_average_scaler;
  import tcmas_pkg::*;

  localparam int WINDOW = 4;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [MODE_W-1:0]      s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  two_channel_moving_average_scaler #(
    .WINDOW_LENGTH(WINDOW)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  logic signed [SAMPLE_W-1:0] ring_mem [2][WINDOW];
  int                         ring_pos [2];
  int                         ring_fill [2];
  int                         ring_sum [2];
  logic                       chan_sel;
  logic [COUNT_W-1:0]         good_tot;
  logic [COUNT_W-1:0]         fault_tot;

  logic signed [GAIN_W-1:0]   gain_volt;
  logic signed [OFFSET_W-1:0] offset_volt;
  logic signed [GAIN_W-1:0]   gain_curr;
  logic signed [OFFSET_W-1:0] offset_curr;

  res_t readings_due [$];
  int   mismatches;
  int   cycle_count;
  int   settings_used;
  int   tx_gap_max;
  int   rx_stall_max;
  int   rx_hold_cycles;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic res_t compute_reading(input logic [MODE_W-1:0] mode,
                                           input logic signed [SAMPLE_W-1:0] sample);
    res_t                       r;
    int                         ch;
    int                         pos;
    logic signed [SAMPLE_W-1:0] avg;
    longint                     prod;
    r = '0;
    ch = int'(chan_sel);
    r.ch = chan_sel;
    if (mode == MODE_GOOD) begin
      pos = ring_pos[ch];
      ring_sum[ch] = ring_sum[ch] - int'(ring_mem[ch][pos]) + int'(sample);
      ring_mem[ch][pos] = sample;
      ring_pos[ch] = (pos + 1) % WINDOW;
      if (ring_fill[ch] < WINDOW) begin
        ring_fill[ch]++;
      end
      avg = SAMPLE_W'(ring_sum[ch] / ring_fill[ch]);
      if (ch == 0) begin
        prod = longint'(avg) * longint'(gain_volt) + longint'(offset_volt);
      end else begin
        prod = longint'(avg) * longint'(gain_curr) + longint'(offset_curr);
      end
      good_tot++;
      r.sample_valid = 1'b1;
      r.raw_value = sample;
      r.average = avg;
      r.scaled = prod[SCALED_W-1:0];
    end else begin
      fault_tot++;
      r.status = 1'b1;
    end
    r.good_count = good_tot;
    r.fault_count = fault_tot;
    chan_sel = ~chan_sel;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : check_readings
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (readings_due.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with none expected, expected none, actual %0h", $time,
                 m_axis_tdata);
      end else begin
        want = readings_due.pop_front();
        check_field("channel", want.ch, m_axis_tuser[0]);
        check_field("sample_valid", want.sample_valid, m_axis_tuser[1]);
        check_field("status", want.status, m_axis_tuser[2]);
        check_field("raw_value", $unsigned(want.raw_value), m_axis_tdata[15:0]);
        check_field("average", $unsigned(want.average), m_axis_tdata[31:16]);
        check_field("scaled_value", $unsigned(want.scaled), m_axis_tdata[71:32]);
        check_field("good_count", want.good_count, m_axis_tdata[103:72]);
        check_field("fault_count", want.fault_count, m_axis_tdata[135:104]);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               readings_due.size());
      $display("FAIL two_channel_moving_average_scaler");
      $finish;
    end
  end

  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        m_axis_tready = 1'b0;
        repeat (rx_hold_cycles) @(negedge clk_i);
        rx_hold_cycles = 0;
      end
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  task automatic push_event(input logic [MODE_W-1:0] mode,
                            input logic [SAMPLE_W-1:0] sample);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = sample;
    s_axis_tuser = mode;
    do @(posedge clk_i); while (!s_axis_tready);
    readings_due.push_back(compute_reading(mode, sample));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (readings_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i = data;
    case (index)
      REG_GAIN_VOLTAGE:   gain_volt = data[GAIN_W-1:0];
      REG_OFFSET_VOLTAGE: offset_volt = data;
      REG_GAIN_CURRENT:   gain_curr = data[GAIN_W-1:0];
      REG_OFFSET_CURRENT: offset_curr = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic program_scaling(input logic [CFG_DATA_W-1:0] gv, input logic [CFG_DATA_W-1:0] ov,
                                 input logic [CFG_DATA_W-1:0] gc, input logic [CFG_DATA_W-1:0] oc);
    write_reg(REG_GAIN_VOLTAGE, gv);
    write_reg(REG_OFFSET_VOLTAGE, ov);
    write_reg(REG_GAIN_CURRENT, gc);
    write_reg(REG_OFFSET_CURRENT, oc);
    cfg_we_i = 1'b0;
    settings_used++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    logic [CFG_DATA_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: v[GAIN_W-1:0] = 24'h7FFFFF;
      1: v[GAIN_W-1:0] = 24'h800000;
      2: v[GAIN_W-1:0] = 24'd4096;
      3: v[GAIN_W-1:0] = 24'($urandom_range(0, 200000)) - 24'd100000;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_offset();
    case ($urandom_range(0, 4))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 16)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    case ($urandom_range(0, 9))
      7: return MODE_START_FAIL;
      8: return MODE_READ_FAIL;
      9: return MODE_UNUSED;
      default: return MODE_GOOD;
    endcase
  endfunction

  task automatic test_directed();
    tx_gap_max = 3;
    rx_stall_max = 3;
    push_event(MODE_GOOD, 16'h7FFF);
    push_event(MODE_GOOD, 16'h8000);
    push_event(MODE_GOOD, 16'h7FFF);
    push_event(MODE_GOOD, 16'h8000);
    push_event(MODE_START_FAIL, 16'h1234);
    push_event(MODE_READ_FAIL, 16'hFFFF);
    push_event(MODE_UNUSED, 16'h8000);
    push_event(MODE_GOOD, 16'hFFFF);
    push_event(MODE_GOOD, 16'h0000);
    push_event(MODE_GOOD, 16'h0001);
    push_event(MODE_GOOD, 16'hFFFE);
    push_event(MODE_GOOD, 16'h0003);
    wait_idle();
    program_scaling({8'hFF, 24'h7FFFFF}, 32'h7FFFFFFF, {8'h00, 24'h800000}, 32'h80000000);
    push_event(MODE_GOOD, 16'h7FFF);
    push_event(MODE_GOOD, 16'h8000);
    push_event(MODE_GOOD, 16'h8000);
    push_event(MODE_GOOD, 16'h7FFF);
    push_event(MODE_READ_FAIL, 16'h0000);
    push_event(MODE_GOOD, 16'h8000);
    wait_idle();
    program_scaling({8'h00, 24'h800000}, 32'h80000000, {8'hA5, 24'h7FFFFF}, 32'h7FFFFFFF);
    push_event(MODE_GOOD, 16'h8000);
    push_event(MODE_GOOD, 16'h7FFF);
    push_event(MODE_GOOD, 16'h8000);
    push_event(MODE_GOOD, 16'h7FFF);
    push_event(MODE_START_FAIL, 16'hFFFF);
    push_event(MODE_GOOD, 16'h8001);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      program_scaling(pick_gain(), pick_offset(), pick_gain(), pick_offset());
      tx_gap_max = (phase == 2) ? 0 : 10;
      rx_stall_max = (phase == 2) ? 0 : 10;
      for (int i = 0; i < 85; i++) begin
        push_event(pick_mode(), pick_sample());
      end
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    program_scaling(pick_gain(), pick_offset(), pick_gain(), pick_offset());
    tx_gap_max = 0;
    rx_stall_max = 0;
    rx_hold_cycles = 120;
    for (int i = 0; i < 12; i++) begin
      push_event(pick_mode(), pick_sample());
    end
    wait_idle();
    tx_gap_max = 10;
    rx_stall_max = 10;
    rx_hold_cycles = 90;
    for (int i = 0; i < 12; i++) begin
      push_event(pick_mode(), pick_sample());
    end
    wait_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    for (int c = 0; c < 2; c++) begin
      ring_pos[c] = 0;
      ring_fill[c] = 0;
      ring_sum[c] = 0;
      for (int k = 0; k < WINDOW; k++) begin
        ring_mem[c][k] = '0;
      end
    end
    chan_sel = 1'b0;
    good_tot = '0;
    fault_tot = '0;
    gain_volt = GAIN_RESET;
    offset_volt = '0;
    gain_curr = GAIN_RESET;
    offset_curr = '0;
    mismatches = 0;
    cycle_count = 0;
    settings_used = 1;
    tx_gap_max = 0;
    rx_stall_max = 0;
    rx_hold_cycles = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_traffic();
    test_backpressure();

    $display("Checked %0d good conversions and %0d bus errors on both channels,",
             good_tot, fault_tot);
    $display("under %0d gain and offset settings with random and long output stalls.",
             settings_used);
    if (mismatches == 0) begin
      $display("PASS two_channel_moving_average_scaler");
    end else begin
      $display("FAIL two_channel_moving_average_scaler");
    end
    $finish;
  end

endmodule
